FILE: rtl/mstk_pkg.sv
// mstk_pkg: types, codes and constants shared by the stack-memory block
// depends on nothing; imported by every module of the block but mstk_ram

package mstk_pkg;

    // default parameter values of the top level
    localparam int DEF_MEM_DEPTH  = 32;
    localparam int DEF_NUM_STACKS = 4;
    localparam int DEF_DATA_WIDTH = 32;

    // fixed field and register widths
    localparam int MAX_RESULTS  = 32;
    localparam int FIELD_W      = 32;
    localparam int ACTION_W     = 2;
    localparam int ID_W         = 2;
    localparam int STATUS_W     = 3;
    localparam int SIU_W        = 3;
    localparam int CAP_W        = 6;
    localparam int NUM_CAP_REGS = 4;
    // sum of up to three capacities of CAP_W bits
    localparam int BASE_W       = CAP_W + 2;

    // configuration port
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_LSB = 2;
    localparam int REG_IDX_W   = PADDR_W - REG_IDX_LSB;

    localparam logic [SIU_W-1:0] SIU_RESET = SIU_W'(4);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH    = 2'd0,
        ACT_POP     = 2'd1,
        ACT_DISPLAY = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_BADID     = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_STACKS_IN_USE = 3'd0,
        REG_CAP0          = 3'd1,
        REG_CAP1          = 3'd2,
        REG_CAP2          = 3'd3,
        REG_CAP3          = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_POP,
        CS_DISPLAY
    } ctrl_state_t;

    // configuration as seen by the controller
    typedef struct packed {
        logic [SIU_W-1:0]                        stacks_in_use;
        logic [NUM_CAP_REGS-1:0][CAP_W-1:0]      cap;
        logic [NUM_CAP_REGS-1:0][BASE_W-1:0]     base;
    } cfg_view_t;

endpackage

FILE: rtl/mstk_ram.sv
// mstk_ram: shared word memory, one write port and one registered read port
// depends on nothing but its parameters

module mstk_ram #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mstk_cfg.sv
// mstk_cfg: configuration registers behind the APB port and stack base sums
// depends on mstk_pkg

module mstk_cfg
    import mstk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_view_t          cfg
);

    logic [SIU_W-1:0] siu_reg;
    logic [CAP_W-1:0] cap_reg [NUM_CAP_REGS];
    logic             wr_en;
    reg_index_t       reg_idx;
    logic [NUM_CAP_REGS-1:0][BASE_W-1:0] base;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_index_t'(paddr[PADDR_W-1:REG_IDX_LSB]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            siu_reg <= SIU_RESET;
            for (int k = 0; k < NUM_CAP_REGS; k++)
            begin
                cap_reg[k] <= CAP_RESET;
            end
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_STACKS_IN_USE: siu_reg    <= pwdata[SIU_W-1:0];
                REG_CAP0:          cap_reg[0] <= pwdata[CAP_W-1:0];
                REG_CAP1:          cap_reg[1] <= pwdata[CAP_W-1:0];
                REG_CAP2:          cap_reg[2] <= pwdata[CAP_W-1:0];
                REG_CAP3:          cap_reg[3] <= pwdata[CAP_W-1:0];
                default:           ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            REG_STACKS_IN_USE: prdata = PDATA_W'(siu_reg);
            REG_CAP0:          prdata = PDATA_W'(cap_reg[0]);
            REG_CAP1:          prdata = PDATA_W'(cap_reg[1]);
            REG_CAP2:          prdata = PDATA_W'(cap_reg[2]);
            REG_CAP3:          prdata = PDATA_W'(cap_reg[3]);
            default:           prdata = '0;
        endcase
    end

    // partition bases: running sum of the capacities below each stack
    always_comb
    begin
        base[0] = '0;
        for (int k = 1; k < NUM_CAP_REGS; k++)
        begin
            base[k] = base[k-1] + BASE_W'(cap_reg[k-1]);
        end
    end

    always_comb
    begin
        cfg.stacks_in_use = siu_reg;
        cfg.base          = base;
        for (int k = 0; k < NUM_CAP_REGS; k++)
        begin
            cfg.cap[k] = cap_reg[k];
        end
    end

endmodule

FILE: rtl/mstk_ctrl.sv
// mstk_ctrl: item sequencer, per-stack fill counters and result register
// depends on mstk_pkg; drives the ports of mstk_ram

module mstk_ctrl
    import mstk_pkg::*;
#(
    parameter int MEM_DEPTH  = DEF_MEM_DEPTH,
    parameter int NUM_STACKS = DEF_NUM_STACKS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int ADDR_W     = $clog2(DEF_MEM_DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_view_t                  cfg,
    // item channel
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic [ACTION_W-1:0]        action,
    input  logic [ID_W-1:0]            stack_id,
    input  logic signed [FIELD_W-1:0]  push_value,
    // result channel
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [STATUS_W-1:0]        status,
    output logic signed [FIELD_W-1:0]  data_value,
    output logic                       last,
    // memory
    output logic                       ram_we,
    output logic [ADDR_W-1:0]          ram_waddr,
    output logic [DATA_WIDTH-1:0]      ram_wdata,
    output logic                       ram_re,
    output logic [ADDR_W-1:0]          ram_raddr,
    input  logic [DATA_WIDTH-1:0]      ram_rdata
);

    localparam int SID_W      = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int DEPTH_BITS = $clog2(MEM_DEPTH + 1);
    localparam int SUM_W      = (DEPTH_BITS > BASE_W + 1) ? DEPTH_BITS : BASE_W + 1;
    localparam int IDX_W      = $clog2(MAX_RESULTS);
    localparam int CNT_W      = $clog2(MAX_RESULTS + 1);
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(MEM_DEPTH);
    localparam logic [CNT_W-1:0] MAXR_C  = CNT_W'(MAX_RESULTS);

    ctrl_state_t          state_reg, state_next;
    logic [CAP_W-1:0]     fill_reg [NUM_STACKS];
    logic [CAP_W-1:0]     fill_next [NUM_STACKS];
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic signed [FIELD_W-1:0] out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;
    logic [BASE_W-1:0]    disp_base_reg, disp_base_next;
    logic [IDX_W-1:0]     disp_idx_reg, disp_idx_next;
    logic [IDX_W-1:0]     disp_end_reg, disp_end_next;
    logic                 pop_zero_reg, pop_zero_next;

    logic                 slot_free;
    logic                 accept;
    logic [SID_W-1:0]     sid;
    logic                 id_bad;
    logic [BASE_W-1:0]    sel_base;
    logic [CAP_W-1:0]     sel_cap;
    logic [CAP_W-1:0]     sel_fill;
    logic [SUM_W-1:0]     top_addr;
    logic [SUM_W-1:0]     pop_addr;
    logic                 overflow;
    logic [SUM_W-1:0]     room;
    logic [CNT_W-1:0]     n_lim;
    logic [CNT_W-1:0]     disp_n;
    logic [IDX_W-1:0]     idx_inc;
    logic signed [FIELD_W-1:0] rd_value;

    // decode of the item on the input side
    assign slot_free  = !out_valid_reg || result_ready;
    assign item_ready = (state_reg == CS_IDLE) && slot_free;
    assign accept     = item_valid && item_ready;
    assign sid        = SID_W'(stack_id);
    assign id_bad     = ({1'b0, stack_id} >= cfg.stacks_in_use)
                        || (SIU_W'(stack_id) >= SIU_W'(NUM_STACKS));
    assign sel_base   = cfg.base[stack_id];
    assign sel_cap    = cfg.cap[stack_id];
    assign sel_fill   = fill_reg[sid];
    assign top_addr   = SUM_W'(sel_base) + SUM_W'(sel_fill);
    assign pop_addr   = top_addr - SUM_W'(1);
    assign overflow   = (sel_fill >= sel_cap) || (top_addr >= DEPTH_S);

    // display length: fill, capped by the result limit and the memory end
    assign room   = (SUM_W'(sel_base) >= DEPTH_S) ? '0 : DEPTH_S - SUM_W'(sel_base);
    assign n_lim  = (CNT_W'(sel_fill) > MAXR_C) ? MAXR_C : CNT_W'(sel_fill);
    assign disp_n = (SUM_W'(n_lim) > room) ? CNT_W'(room) : n_lim;

    assign idx_inc  = disp_idx_reg + IDX_W'(1);
    assign rd_value = FIELD_W'($signed(ram_rdata));

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_STACKS; k++)
            begin
                fill_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        disp_base_reg  <= disp_base_next;
        disp_idx_reg   <= disp_idx_next;
        disp_end_reg   <= disp_end_next;
        pop_zero_reg   <= pop_zero_next;
    end

    // next state, memory accesses and result loading
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        disp_base_next  = disp_base_reg;
        disp_idx_next   = disp_idx_reg;
        disp_end_next   = disp_end_reg;
        pop_zero_next   = pop_zero_reg;
        ram_we          = 1'b0;
        ram_waddr       = ADDR_W'(top_addr);
        ram_wdata       = DATA_WIDTH'(push_value);
        ram_re          = 1'b0;
        ram_raddr       = ADDR_W'(pop_addr);

        case (state_reg)
            CS_IDLE:
            begin
                if (accept && (action != ACT_PUSH) && (action != ACT_POP)
                    && (action != ACT_DISPLAY))
                begin
                    // unused action: dropped without a result
                end
                else if (accept && id_bad)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_BADID;
                    out_data_next   = '0;
                    out_last_next   = 1'b1;
                end
                else if (accept)
                begin
                    case (action_t'(action))
                        ACT_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                            out_last_next  = 1'b1;
                            if (overflow)
                            begin
                                out_status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                out_status_next = ST_OK;
                                ram_we          = 1'b1;
                                fill_next[sid]  = sel_fill + CAP_W'(1);
                            end
                        end
                        ACT_POP:
                        begin
                            if (sel_fill == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_UNDERFLOW;
                                out_data_next   = '0;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                fill_next[sid] = sel_fill - CAP_W'(1);
                                pop_zero_next  = (pop_addr >= DEPTH_S);
                                ram_re         = (pop_addr < DEPTH_S);
                                state_next     = CS_POP;
                            end
                        end
                        ACT_DISPLAY:
                        begin
                            if (disp_n == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_EMPTY;
                                out_data_next   = '0;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                ram_re         = 1'b1;
                                ram_raddr      = ADDR_W'(sel_base);
                                disp_base_next = sel_base;
                                disp_idx_next  = '0;
                                disp_end_next  = IDX_W'(disp_n - CNT_W'(1));
                                state_next     = CS_DISPLAY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // popped word is in the read register
            CS_POP:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_data_next   = pop_zero_reg ? '0 : rd_value;
                    out_last_next   = 1'b1;
                    state_next      = CS_IDLE;
                end
            end

            // one entry per cycle while slot_free; next read issued at each load
            CS_DISPLAY:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_data_next   = rd_value;
                    out_last_next   = (disp_idx_reg == disp_end_reg);
                    if (disp_idx_reg == disp_end_reg)
                    begin
                        state_next = CS_IDLE;
                    end
                    else
                    begin
                        ram_re        = 1'b1;
                        ram_raddr     = ADDR_W'(SUM_W'(disp_base_reg) + SUM_W'(idx_inc));
                        disp_idx_next = idx_inc;
                    end
                end
            end

            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign data_value   = out_data_reg;
    assign last         = out_last_reg;

endmodule

FILE: rtl/multiple_stacks_one_memory_core.sv
// multiple_stacks_one_memory_core: several stacks partitioned in one shared memory
// depends on mstk_pkg, mstk_cfg, mstk_ctrl and mstk_ram
//
// Usage
//   Item channel (item_valid/item_ready): action, stack_id, push_value.
//   Result channel (result_valid/result_ready): status, data_value, last;
//   last marks the final result of an item.
//   The APB port holds stacks_in_use at 0x00 and the four capacities at
//   0x04..0x10; a stack's base is the sum of the capacities below it.
//   Push, bad id, overflow, underflow and empty display: one result, valid
//   the cycle after the item is taken; the next item is taken that cycle if
//   result_ready is high. Pop: the word goes via the memory read register,
//   then the result register. Display of n entries: one result per cycle while
//   result_ready is high, paced by the single read port; no item meanwhile.
//   A result waits in the output register while result_ready is low; the
//   block then takes no new item and the display walk pauses.
//   Reset empties all stacks and restores four stacks of eight entries;
//   memory words are not cleared and no clearing pass is needed.

module multiple_stacks_one_memory_core
    import mstk_pkg::*;
#(
    parameter int MEM_DEPTH  = DEF_MEM_DEPTH,
    parameter int NUM_STACKS = DEF_NUM_STACKS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    // items
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic [ACTION_W-1:0]        action,
    input  logic [ID_W-1:0]            stack_id,
    input  logic signed [FIELD_W-1:0]  push_value,
    // results
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [STATUS_W-1:0]        status,
    output logic signed [FIELD_W-1:0]  data_value,
    output logic                       last
);

    localparam int ADDR_W = $clog2(MEM_DEPTH);

    cfg_view_t             cfg;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // configuration registers
    mstk_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer and fill counters
    mstk_ctrl #(
        .MEM_DEPTH  (MEM_DEPTH),
        .NUM_STACKS (NUM_STACKS),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .stack_id     (stack_id),
        .push_value   (push_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .data_value   (data_value),
        .last         (last),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    // shared stack memory
    mstk_ram #(
        .DEPTH  (MEM_DEPTH),
        .WIDTH  (DATA_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

FILE: rtl/mstk_checker.sv
// mstk_checker: port-level checks on the stack-memory block, bound to the top level
// depends on mstk_pkg and multiple_stacks_one_memory_core

module mstk_checker
    import mstk_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic [ACTION_W-1:0] action,
    input logic                result_valid,
    input logic                result_ready,
    input logic [STATUS_W-1:0] status,
    input logic [FIELD_W-1:0]  data_value,
    input logic                last
);

    // a stalled result holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(status) && $stable(data_value) && $stable(last))
        else $error("result changed while stalled");

    // every error or empty report is a lone result carrying zero
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != ST_OK) |-> (data_value == '0) && last)
        else $error("error result not final or data not zero");

    // no new item while the output register is blocked
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !item_ready)
        else $error("item taken while result stalled");

    // a taken pop either holds off items during its memory read or reports at once
    a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (action == ACT_POP) |=> !item_ready || result_valid)
        else $error("item taken during pop read");

endmodule

bind multiple_stacks_one_memory_core mstk_checker u_mstk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .data_value   (data_value),
    .last         (last)
);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for multiple_stacks_one_memory_core
// depends on mstk_pkg and the core; keeps a shadow of the stacks to predict results

module tb_top;
    import mstk_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      psel         = 1'b0;
    logic                      penable      = 1'b0;
    logic                      pwrite       = 1'b0;
    logic [PADDR_W-1:0]        paddr        = '0;
    logic [PDATA_W-1:0]        pwdata       = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      item_valid   = 1'b0;
    logic                      item_ready;
    logic [ACTION_W-1:0]       action       = ACT_PUSH;
    logic [ID_W-1:0]           stack_id     = '0;
    logic signed [FIELD_W-1:0] push_value   = '0;
    logic                      result_valid;
    logic                      result_ready = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic signed [FIELD_W-1:0] data_value;
    logic                      last;

    typedef struct {
        status_t            st;
        logic [FIELD_W-1:0] data;
        logic               last;
    } stack_result_t;

    // shadow of the block: memory, fill counts and configuration
    logic [FIELD_W-1:0] shadow_mem [DEF_MEM_DEPTH];
    int                 shadow_fill [DEF_NUM_STACKS];
    int                 shadow_cap [NUM_CAP_REGS];
    int                 shadow_siu;

    stack_result_t      pending_results [$];
    int                 mismatch_count = 0;
    bit                 steady_flow    = 1'b0;
    int unsigned        quiet_cycles   = 0;

    multiple_stacks_one_memory_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .stack_id     (stack_id),
        .push_value   (push_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .data_value   (data_value),
        .last         (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // expected results

    function automatic void queue_result(status_t st, logic [FIELD_W-1:0] data, logic fin);
        stack_result_t r;
        r.st   = st;
        r.data = data;
        r.last = fin;
        pending_results.push_back(r);
    endfunction

    // entries past the end of memory read as zero
    function automatic logic [FIELD_W-1:0] shadow_read(int addr);
        return (addr >= DEF_MEM_DEPTH) ? '0 : shadow_mem[addr];
    endfunction

    function automatic void predict_stack_op(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                                             logic [FIELD_W-1:0] val);
        int base;
        int fill;
        int n;
        int k;
        base = 0;
        if (act == ACT_UNUSED)
            return;
        if (int'(id) >= shadow_siu || int'(id) >= DEF_NUM_STACKS)
        begin
            queue_result(ST_BADID, '0, 1'b1);
            return;
        end
        for (k = 0; k < int'(id); k++)
            base += shadow_cap[k];
        fill = shadow_fill[id];
        case (act)
            ACT_PUSH:
            begin
                if (fill >= shadow_cap[id] || base + fill >= DEF_MEM_DEPTH)
                    queue_result(ST_OVERFLOW, '0, 1'b1);
                else
                begin
                    shadow_mem[base + fill] = val;
                    shadow_fill[id] = fill + 1;
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            ACT_POP:
            begin
                if (fill == 0)
                    queue_result(ST_UNDERFLOW, '0, 1'b1);
                else
                begin
                    shadow_fill[id] = fill - 1;
                    queue_result(ST_OK, shadow_read(base + fill - 1), 1'b1);
                end
            end
            default:
            begin
                // display stops at the result limit and at the memory end
                n = (fill > MAX_RESULTS) ? MAX_RESULTS : fill;
                if (base >= DEF_MEM_DEPTH)
                    n = 0;
                else if (n > DEF_MEM_DEPTH - base)
                    n = DEF_MEM_DEPTH - base;
                if (n == 0)
                    queue_result(ST_EMPTY, '0, 1'b1);
                else
                    for (k = 0; k < n; k++)
                        queue_result(ST_OK, shadow_read(base + k), k == n - 1);
            end
        endcase
    endfunction

    // item channel

    task automatic send_item(logic [ACTION_W-1:0] act, logic [ID_W-1:0] id,
                             logic [FIELD_W-1:0] val);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(99) < 12)
            gap = 1;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        action     <= act;
        stack_id   <= id;
        push_value <= val;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_stack_op(act, id, val);
    endtask

    // drop valid and let every outstanding result drain
    task automatic settle_block();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write followed by a read-back
    task automatic write_register(reg_index_t idx, int unsigned value);
        int unsigned kept;
        kept = (idx == REG_STACKS_IN_USE) ? (value & ((1 << SIU_W) - 1))
                                          : (value & ((1 << CAP_W) - 1));
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << REG_IDX_LSB;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== PDATA_W'(kept))
        begin
            $display("%0t: register %s read-back: expected %h, actual %h",
                     $time, idx.name(), PDATA_W'(kept), prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_STACKS_IN_USE)
            shadow_siu = kept;
        else
            shadow_cap[int'(idx) - int'(REG_CAP0)] = kept;
    endtask

    // empty every stack under the current layout, then load a new one
    task automatic apply_setting(int unsigned siu, int unsigned c0, int unsigned c1,
                                 int unsigned c2, int unsigned c3);
        int k;
        int n;
        settle_block();
        if (shadow_siu < DEF_NUM_STACKS)
            write_register(REG_STACKS_IN_USE, DEF_NUM_STACKS);
        for (k = 0; k < DEF_NUM_STACKS; k++)
        begin
            n = shadow_fill[k];
            repeat (n) send_item(ACT_POP, ID_W'(k), $urandom());
        end
        settle_block();
        write_register(REG_STACKS_IN_USE, siu);
        write_register(REG_CAP0, c0);
        write_register(REG_CAP1, c1);
        write_register(REG_CAP2, c2);
        write_register(REG_CAP3, c3);
    endtask

    task automatic run_traffic(int n_items, int push_pct, int pop_pct, int show_pct);
        int i;
        int roll;
        int live;
        logic [ACTION_W-1:0] act;
        logic [ID_W-1:0]     id;
        logic [FIELD_W-1:0]  val;
        for (i = 0; i < n_items; i++)
        begin
            roll = $urandom_range(99);
            if (roll < push_pct)
                act = ACT_PUSH;
            else if (roll < push_pct + pop_pct)
                act = ACT_POP;
            else if (roll < push_pct + pop_pct + show_pct)
                act = ACT_DISPLAY;
            else
                act = ACT_UNUSED;
            // mostly stacks in use, sometimes any id
            live = (shadow_siu < DEF_NUM_STACKS) ? shadow_siu : DEF_NUM_STACKS;
            if (live > 0 && $urandom_range(99) < 88)
                id = ID_W'($urandom_range(live - 1));
            else
                id = ID_W'($urandom_range(DEF_NUM_STACKS - 1));
            case ($urandom_range(9))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7fff_ffff;
                2:       val = 32'hffff_ffff;
                3:       val = '0;
                default: val = $urandom();
            endcase
            send_item(act, id, val);
        end
    endtask

    // tests

    task automatic test_push_pop_extremes();
        send_item(ACT_PUSH, 2'd0, 32'h7fff_ffff);
        send_item(ACT_PUSH, 2'd0, 32'h8000_0000);
        send_item(ACT_PUSH, 2'd0, 32'hffff_ffff);
        send_item(ACT_PUSH, 2'd0, 32'h0000_0000);
        send_item(ACT_POP,  2'd0, 32'hffff_ffff);
        // pop of an empty stack
        send_item(ACT_POP,  2'd1, 32'h0);
    endtask

    task automatic test_display_and_unused();
        send_item(ACT_DISPLAY, 2'd0, 32'h0);
        send_item(ACT_DISPLAY, 2'd2, 32'h0);
        // unused action is dropped without a result
        send_item(ACT_UNUSED, 2'd1, $urandom());
    endtask

    task automatic test_partition_edges();
        // stack three sits on the last two words of memory
        settle_block();
        write_register(REG_CAP0, 10);
        write_register(REG_CAP1, 10);
        write_register(REG_CAP2, 10);
        write_register(REG_CAP3, 2);
        send_item(ACT_PUSH, 2'd3, 32'h1234_5678);
        send_item(ACT_PUSH, 2'd3, 32'hcafe_f00d);
        send_item(ACT_PUSH, 2'd3, 32'h5555_aaaa);
        // room in the partition but not in memory
        settle_block();
        write_register(REG_CAP3, 4);
        send_item(ACT_PUSH, 2'd3, 32'haaaa_5555);
        // base moved up: display clipped at the memory end, pop past it
        settle_block();
        write_register(REG_CAP0, 11);
        send_item(ACT_DISPLAY, 2'd3, 32'h0);
        send_item(ACT_POP, 2'd3, 32'h0);
        // base right at the memory end
        settle_block();
        write_register(REG_CAP0, 12);
        send_item(ACT_DISPLAY, 2'd3, 32'h0);
        send_item(ACT_PUSH, 2'd3, 32'h0f0f_0f0f);
        settle_block();
        write_register(REG_CAP0, 10);
        send_item(ACT_POP, 2'd3, 32'h0);
    endtask

    task automatic test_stack_count();
        settle_block();
        write_register(REG_STACKS_IN_USE, 2);
        send_item(ACT_PUSH, 2'd2, 32'h0000_0001);
        send_item(ACT_DISPLAY, 2'd3, 32'h0);
        send_item(ACT_POP, 2'd1, 32'h0);
        // no stack in use: every id is bad
        settle_block();
        write_register(REG_STACKS_IN_USE, 0);
        send_item(ACT_POP, 2'd0, 32'h0);
        settle_block();
        write_register(REG_STACKS_IN_USE, 7);
        send_item(ACT_PUSH, 2'd3, 32'hdead_beef);
        send_item(ACT_DISPLAY, 2'd3, 32'h0);
        send_item(ACT_POP, 2'd3, 32'h0);
    endtask

    task automatic test_capacity_extremes();
        settle_block();
        write_register(REG_CAP1, 0);
        send_item(ACT_PUSH, 2'd1, 32'h0000_0002);
        send_item(ACT_DISPLAY, 2'd1, 32'h0);
        // widest stack zero pushes the later stacks off the memory
        settle_block();
        write_register(REG_CAP0, 63);
        send_item(ACT_PUSH, 2'd0, 32'h7777_8888);
        send_item(ACT_PUSH, 2'd2, 32'h9999_0000);
    endtask

    task automatic test_random_traffic();
        apply_setting(4, 8, 8, 8, 8);
        steady_flow = 1'b1;
        run_traffic(30, 50, 25, 15);
        steady_flow = 1'b0;
        apply_setting(3, 2, 3, 1, 32);
        run_traffic(25, 45, 30, 15);
        // one stack owning the whole memory, long displays
        apply_setting(1, 32, 0, 0, 0);
        run_traffic(35, 70, 10, 15);
        apply_setting(4, 0, 16, 16, 5);
        run_traffic(20, 45, 30, 15);
        apply_setting(2, $urandom_range(32), $urandom_range(32), $urandom_range(32),
                      $urandom_range(32));
        run_traffic(25, 45, 30, 15);
        apply_setting($urandom_range(7), $urandom_range(63), $urandom_range(63),
                      $urandom_range(63), $urandom_range(63));
        run_traffic(25, 45, 30, 15);
        apply_setting(4, $urandom_range(16, 1), $urandom_range(16, 1),
                      $urandom_range(16, 1), $urandom_range(16, 1));
        run_traffic(30, 50, 30, 15);
    endtask

    // result channel: compare each result, then pick the next ready
    always @(posedge clk)
    begin : result_check
        stack_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected: status %0d data %h last %0b",
                         $time, status, data_value, last);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st || data_value !== want.data || last !== want.last)
                begin
                    $display("%0t: mismatch: expected %0d/%h/%0b, actual %0d/%h/%0b",
                             $time, want.st, want.data, want.last, status, data_value,
                             last);
                    mismatch_count++;
                end
            end
        end
        result_ready <= steady_flow || ($urandom_range(99) >= 12);
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        shadow_siu = SIU_RESET;
        for (int k = 0; k < NUM_CAP_REGS; k++)
            shadow_cap[k] = CAP_RESET;
        for (int k = 0; k < DEF_NUM_STACKS; k++)
            shadow_fill[k] = 0;
        for (int k = 0; k < DEF_MEM_DEPTH; k++)
            shadow_mem[k] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_push_pop_extremes();
        test_display_and_unused();
        test_partition_edges();
        test_stack_count();
        test_capacity_extremes();
        test_random_traffic();
        settle_block();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mstk_pkg.sv
rtl/mstk_ram.sv
rtl/mstk_cfg.sv
rtl/mstk_ctrl.sv
rtl/multiple_stacks_one_memory_core.sv
rtl/mstk_checker.sv
verif/tb_top.sv
